[hw/rtl/clt_pkg.sv]
// Shared types and constants of the per-address connection limiter.
package clt_pkg;

   localparam int TableEntriesDefault = 1024;
   localparam int CountBitsDefault    = 16;

   localparam int ACTION_W   = 2;
   localparam int ADDR_W     = 64;
   localparam int KEY_W      = 1 + 2 * ADDR_W;
   localparam int LIMIT_W    = 16;
   localparam int DISTINCT_W = 11;
   localparam int TOTAL_W    = 26;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TOTAL_W-1:0]    TOTAL_MAX      = {TOTAL_W{1'b1}};
   localparam logic [DISTINCT_W-1:0] DISTINCT_RESET = 11'd1024;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TRACK   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;

   // register indexes
   localparam logic REG_LIMIT_PER_ADDRESS = 1'b0;
   localparam logic REG_LIMIT_DISTINCT    = 1'b1;

   typedef struct packed {
      logic [LIMIT_W-1:0]    limit_per_address;
      logic [DISTINCT_W-1:0] limit_distinct;
   } cfg_type;

endpackage

[hw/rtl/clt_req_if.sv]
// Request channel of the connection limiter.
interface clt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic        has_address;
   logic        is_ipv6;
   logic [63:0] address_high;
   logic [63:0] address_low;

   modport source(output valid, action, has_address, is_ipv6, address_high, address_low,
                  input ready);
   modport sink(input valid, action, has_address, is_ipv6, address_high, address_low,
                output ready);
endinterface

[hw/rtl/clt_rsp_if.sv]
// Response channel of the connection limiter.
interface clt_rsp_if;
   logic        valid;
   logic        ready;
   logic        allowed;
   logic [15:0] address_count;
   logic [25:0] total_connections;
   logic [10:0] distinct_addresses;

   modport source(output valid, allowed, address_count, total_connections,
                  distinct_addresses, input ready);
   modport sink(input valid, allowed, address_count, total_connections,
                distinct_addresses, output ready);
endinterface

[hw/rtl/clt_csr.sv]
// APB register block holding the two limits.
module clt_csr
   import clt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // write registers on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_per_address <= '0;
         cfg_ff.limit_distinct    <= DISTINCT_RESET;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_LIMIT_PER_ADDRESS: cfg_ff.limit_per_address <= csr_pwdata[LIMIT_W-1:0];
            REG_LIMIT_DISTINCT:    cfg_ff.limit_distinct    <= csr_pwdata[DISTINCT_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_paddr[2])
         REG_LIMIT_PER_ADDRESS:
            csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.limit_per_address};
         REG_LIMIT_DISTINCT:
            csr_prdata = {{(CSR_DATA_W-DISTINCT_W){1'b0}}, cfg_ff.limit_distinct};
         default: csr_prdata = '0;
      endcase
   end

endmodule

[hw/rtl/clt_engine.sv]
// Entry table in one memory with scan, decision and compaction sequencer.
module clt_engine
   import clt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault,
   parameter int COUNT_BITS    = CountBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   clt_req_if.sink   req_ch,
   clt_rsp_if.source rsp_ch
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ENT_W  = KEY_W + COUNT_BITS;
   localparam int CMP_W  = 32;
   localparam int FCMP_W = (FILL_W > DISTINCT_W) ? FILL_W : DISTINCT_W;
   localparam logic [COUNT_BITS-1:0] COUNT_CEIL = {{(COUNT_BITS-1){1'b1}}, 1'b0};
   localparam logic [FILL_W-1:0]     FILL_FULL  = FILL_W'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_MOVE_RD, ST_MOVE_WR, ST_RESP
   } state_type;

   logic [ENT_W-1:0] mem [TABLE_ENTRIES];

   state_type              state_ff;
   logic [ACTION_W-1:0]    act_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [FILL_W-1:0]      scan_ff;
   logic                   pend_ff;
   logic [IDX_W-1:0]       pend_idx_ff;
   logic [ENT_W-1:0]       rd_ff;
   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic [COUNT_BITS-1:0]  hit_cnt_ff;
   logic [FILL_W-1:0]      fill_ff;
   logic [TOTAL_W-1:0]     total_ff;
   logic                   res_allowed_ff;
   logic [COUNT_BITS-1:0]  res_cnt_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_allowed_ff;
   logic [LIMIT_W-1:0]     rsp_cnt_ff;
   logic [TOTAL_W-1:0]     rsp_total_ff;
   logic [DISTINCT_W-1:0]  rsp_distinct_ff;

   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENT_W-1:0]       wr_data;
   logic [KEY_W-1:0]       req_key;
   logic                   req_fire;
   logic                   issue;
   logic                   match;
   logic [COUNT_BITS-1:0]  rd_cnt;
   logic [COUNT_BITS-1:0]  cnt_inc;
   logic [COUNT_BITS-1:0]  cnt_dec;
   logic                   distinct_block;
   logic                   per_addr_ok;
   logic                   rsp_load;

   assign req_fire = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_load = (state_ff == ST_RESP) & (~rsp_valid_ff | rsp_ch.ready);

   // normalize the key: an IPv4 address keeps only its low 32 bits
   assign req_key = {req_ch.is_ipv6,
                     req_ch.is_ipv6 ? req_ch.address_high : {ADDR_W{1'b0}},
                     req_ch.is_ipv6 ? req_ch.address_low
                                    : {32'd0, req_ch.address_low[31:0]}};

   assign issue   = (state_ff == ST_SCAN) & (scan_ff < fill_ff);
   assign rd_cnt  = rd_ff[COUNT_BITS-1:0];
   assign match   = pend_ff & (rd_cnt != '0) & (rd_ff[ENT_W-1:COUNT_BITS] == key_ff);
   assign cnt_inc = hit_cnt_ff + 1'b1;
   assign cnt_dec = hit_cnt_ff - 1'b1;

   assign distinct_block = (cfg.limit_distinct != '0) &&
                           (FCMP_W'(fill_ff) >= FCMP_W'(cfg.limit_distinct));
   assign per_addr_ok    = (cfg.limit_per_address == '0) ||
                           (CMP_W'(hit_cnt_ff) + CMP_W'(1) <=
                            CMP_W'(cfg.limit_per_address));

   // memory port selection
   always_comb begin
      rd_addr = scan_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_data = {key_ff, cnt_inc};
      case (state_ff)
         ST_MOVE_RD: rd_addr = fill_ff[IDX_W-1:0];
         ST_DECIDE: begin
            if (hit_ff) begin
               if (act_ff == ACT_TRACK) begin
                  wr_en = (hit_cnt_ff < COUNT_CEIL) && (total_ff < TOTAL_MAX) && per_addr_ok;
               end else if (act_ff == ACT_RELEASE) begin
                  wr_en   = 1'b1;
                  wr_data = {key_ff, cnt_dec};
               end
            end else if (act_ff == ACT_TRACK) begin
               wr_en   = !distinct_block && (total_ff < TOTAL_MAX) && (fill_ff != FILL_FULL);
               wr_addr = fill_ff[IDX_W-1:0];
               wr_data = {key_ff, COUNT_BITS'(1)};
            end
         end
         ST_MOVE_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_ff;
         end
         default: ;
      endcase
   end

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // sequencer and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  act_ff         <= req_ch.action;
                  key_ff         <= req_key;
                  scan_ff        <= '0;
                  pend_ff        <= 1'b0;
                  res_allowed_ff <= (req_ch.action == ACT_TRACK);
                  res_cnt_ff     <= '0;
                  state_ff       <= req_ch.has_address ? ST_SCAN : ST_RESP;
               end
            end
            ST_SCAN: begin
               // stream reads; compare the entry that arrived
               pend_ff     <= issue;
               pend_idx_ff <= scan_ff[IDX_W-1:0];
               if (issue) begin
                  scan_ff <= scan_ff + 1'b1;
               end
               if (match) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= pend_idx_ff;
                  hit_cnt_ff <= rd_cnt;
                  state_ff   <= ST_DECIDE;
               end else if (!pend_ff && !issue) begin
                  hit_ff   <= 1'b0;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               // entry freed: move the last entry into the hole
               state_ff <= (hit_ff && (act_ff == ACT_RELEASE) && (cnt_dec == '0)) ?
                           ST_MOVE_RD : ST_RESP;
               if (hit_ff) begin
                  if (act_ff == ACT_TRACK) begin
                     res_allowed_ff <= wr_en;
                     res_cnt_ff     <= wr_en ? cnt_inc : hit_cnt_ff;
                     if (wr_en) begin
                        total_ff <= total_ff + 1'b1;
                     end
                  end else if (act_ff == ACT_RELEASE) begin
                     res_allowed_ff <= 1'b0;
                     res_cnt_ff     <= cnt_dec;
                     if (total_ff != '0) begin
                        total_ff <= total_ff - 1'b1;
                     end
                     if (cnt_dec == '0) begin
                        fill_ff <= fill_ff - 1'b1;
                     end
                  end else begin
                     res_allowed_ff <= 1'b0;
                     res_cnt_ff     <= hit_cnt_ff;
                  end
               end else if (act_ff == ACT_TRACK) begin
                  if (wr_en) begin
                     res_allowed_ff <= 1'b1;
                     res_cnt_ff     <= COUNT_BITS'(1);
                     fill_ff        <= fill_ff + 1'b1;
                     total_ff       <= total_ff + 1'b1;
                  end else begin
                     res_allowed_ff <= !distinct_block && (total_ff < TOTAL_MAX) &&
                                       (cfg.limit_per_address == '0);
                     res_cnt_ff     <= '0;
                  end
               end else begin
                  res_allowed_ff <= 1'b0;
                  res_cnt_ff     <= '0;
               end
            end
            ST_MOVE_RD: state_ff <= ST_MOVE_WR;
            ST_MOVE_WR: state_ff <= ST_RESP;
            ST_RESP: begin
               if (rsp_load) begin
                  rsp_allowed_ff  <= res_allowed_ff;
                  rsp_cnt_ff      <= LIMIT_W'(CMP_W'(res_cnt_ff));
                  rsp_total_ff    <= total_ff;
                  rsp_distinct_ff <= DISTINCT_W'(FCMP_W'(fill_ff));
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.allowed            = rsp_allowed_ff;
   assign rsp_ch.address_count      = rsp_cnt_ff;
   assign rsp_ch.total_connections  = rsp_total_ff;
   assign rsp_ch.distinct_addresses = rsp_distinct_ff;

endmodule

[hw/rtl/per_address_connection_limiter_top.sv]
// Top level of the per-address connection limiter.
//
//  Channel   Role        Handshake        Contents
//  req_ch    in          valid/ready      action, address, family
//  rsp_ch    out         valid/ready      decision and counters
//  csr_*     config      APB, pready=1    limit_per_address @0, limit_distinct @4
//
// An item with an address reads the entry memory one entry a cycle, over the N
// entries in use, until the address is found. A release that frees an entry
// then moves the last entry down into the hole, a read step and then a write step.
// Items without an address skip the scan and go straight to the response step.
// Reset is synchronous and leaves the table empty at once. A stalled response
// keeps the following item in its response step and holds later requests back.
module per_address_connection_limiter_top
   import clt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault,
   parameter int COUNT_BITS    = CountBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   clt_req_if.sink               req_ch,
   clt_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   clt_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   clt_engine #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .COUNT_BITS(COUNT_BITS)
   ) u_engine (
      .clock, .reset, .cfg, .req_ch, .rsp_ch
   );

endmodule

[hw/rtl/clt_checker.sv]
// Port-level checks of the connection limiter, bound to the top level.
module clt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_allowed,
   input logic [15:0] rsp_count,
   input logic [25:0] rsp_total,
   input logic        csr_pready
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // drop valid right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a counted connection shows in the total
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_allowed && (rsp_count != 16'd0) |-> (rsp_total != 26'd0))
      else $error("allowed connection missing from total");

   // config port never waits
   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("config port stalled");

endmodule

bind per_address_connection_limiter_top clt_checker u_clt_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_allowed(rsp_ch.allowed),
   .rsp_count(rsp_ch.address_count),
   .rsp_total(rsp_ch.total_connections),
   .csr_pready(csr_pready)
);
